// ===== sv/cmns_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cmns_pkg
// Shared types and constants of the closest meeting node search block.
// ---------------------------------------------------------------------------
package cmns_pkg;

   // field and store widths
   localparam int NODE_W  = 10;
   localparam int COUNT_W = 11;
   localparam int DIST_W  = 11;
   localparam int SUCC_W  = 11;

   // successor table depth addressed by a node field
   localparam int TABLE_DEPTH       = 1024;
   localparam int MAX_NODES_DEFAULT = 1024;

   // node count after reset
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

   // distance code of a node not reached by a walk
   localparam logic [DIST_W-1:0] UNREACHED = 11'h7FF;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // input item
   typedef struct packed {
      logic              req_type;
      logic [NODE_W-1:0] node_index;
      logic              has_edge;
      logic [NODE_W-1:0] edge_target;
      logic [NODE_W-1:0] start_a;
      logic [NODE_W-1:0] start_b;
   } req_item_type;

   // result item
   typedef struct packed {
      logic              found;
      logic [NODE_W-1:0] meeting_node;
   } rsp_item_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic              init;
      logic              eval;
      logic [NODE_W-1:0] node;
   } eval_ctrl_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage
`default_nettype wire

// ===== sv/closest_meeting_node_search.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// closest_meeting_node_search
// Successor table of a graph with at most one edge per node, and a search
// for the closest node reachable from two start nodes.
// ---------------------------------------------------------------------------
// A load item writes one successor entry and returns nothing.
// A query item walks from start_a, then from start_b, one node per cycle,
// and then scans nodes 0 to n-1 one per cycle, n being node_count limited
// to the table depth. The registered reads of the successor and distance
// memories give one walk step or one scanned node per cycle. The scan also
// restores the distance memories to unreached. After reset a clearing pass
// over min(MAX_NODES, 1024) nodes runs before the first item is taken; csr
// writes are taken at any time. The block takes no new item until a query's
// result has gone into the output register.
// ---------------------------------------------------------------------------
module closest_meeting_node_search
   import cmns_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_item_type        req_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_item_type             rsp_item,
   input  wire logic                csr_wr_en,
   input  wire logic [COUNT_W-1:0]  csr_wr_data
);

   localparam int NODE_DEPTH = (MAX_NODES < TABLE_DEPTH) ? MAX_NODES : TABLE_DEPTH;
   localparam int ADDR_W     = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
   localparam logic [COUNT_W-1:0] NODE_LIMIT = COUNT_W'(NODE_DEPTH);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] node_count_ff;
   logic [COUNT_W-1:0] n_w;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic               fwd_ff, fwd_in;
   logic               walk_b_ff, walk_b_in;
   logic [NODE_W-1:0]  start_b_ff, start_b_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [NODE_W-1:0]  scan_node_ff, scan_node_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff;
   logic               rsp_load;

   logic               succ_we;
   logic [SUCC_W-1:0]  succ_wdata;
   logic [SUCC_W-1:0]  succ_rdata;
   logic [ADDR_W-1:0]  rd_addr;
   logic               dist_a_we, dist_b_we;
   logic [ADDR_W-1:0]  dist_waddr;
   logic [DIST_W-1:0]  dist_wdata;
   logic [DIST_W-1:0]  dist_a_rdata, dist_b_rdata;
   logic [DIST_W-1:0]  walk_rdist;
   logic               walk_take, walk_move, walk_write;
   logic [NODE_W-1:0]  next_node;
   eval_ctrl_type      eval_ctrl;
   logic               best_found;
   logic [NODE_W-1:0]  best_node;

   // nodes in use
   assign n_w = (node_count_ff > NODE_LIMIT) ? NODE_LIMIT : node_count_ff;

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // walk step decode on the registered reads of the current node
   always_comb begin
      walk_rdist = walk_b_ff ? dist_b_rdata : dist_a_rdata;
      walk_take  = (COUNT_W'(cur_ff) < n_w) && !fwd_ff && (walk_rdist == UNREACHED);
      walk_move  = walk_take && succ_rdata[SUCC_W-1];
      next_node  = succ_rdata[NODE_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      dist_in      = dist_ff;
      fwd_in       = 1'b0;
      walk_b_in    = walk_b_ff;
      start_b_in   = start_b_ff;
      rd_valid_in  = 1'b0;
      scan_node_in = scan_node_ff;
      req_ready    = 1'b0;
      succ_we      = 1'b0;
      succ_wdata   = req_item.has_edge ? {1'b1, req_item.edge_target} : '0;
      rd_addr      = cur_ff[ADDR_W-1:0];
      dist_a_we    = 1'b0;
      dist_b_we    = 1'b0;
      dist_waddr   = cur_ff[ADDR_W-1:0];
      dist_wdata   = UNREACHED;
      walk_write   = 1'b0;
      eval_ctrl    = '{init: 1'b0, eval: 1'b0, node: scan_node_ff};
      rsp_load     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            dist_a_we  = 1'b1;
            dist_b_we  = 1'b1;
            dist_waddr = idx_ff[ADDR_W-1:0];
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == NODE_LIMIT - 1'b1) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_item.req_type == REQ_QUERY) begin
                  rd_addr    = req_item.start_a[ADDR_W-1:0];
                  cur_in     = req_item.start_a;
                  dist_in    = '0;
                  walk_b_in  = 1'b0;
                  start_b_in = req_item.start_b;
                  state_in   = ST_WALK;
               end else begin
                  succ_we = COUNT_W'(req_item.node_index) < NODE_LIMIT;
               end
            end
         end
         ST_WALK: begin
            // record the first distance of this node
            if (walk_take) begin
               walk_write = 1'b1;
               dist_a_we  = !walk_b_ff;
               dist_b_we  = walk_b_ff;
               dist_wdata = dist_ff;
               dist_in    = dist_ff + 1'b1;
            end
            if (walk_move) begin
               // follow the edge; a self loop sees its own write late
               rd_addr = next_node[ADDR_W-1:0];
               cur_in  = next_node;
               fwd_in  = (next_node == cur_ff);
            end else if (!walk_b_ff) begin
               rd_addr   = start_b_ff[ADDR_W-1:0];
               cur_in    = start_b_ff;
               dist_in   = '0;
               walk_b_in = 1'b1;
            end else begin
               idx_in         = '0;
               eval_ctrl.init = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read one node, compare and clear the node read before
            if (idx_ff < n_w) begin
               rd_addr      = idx_ff[ADDR_W-1:0];
               rd_valid_in  = 1'b1;
               scan_node_in = idx_ff[NODE_W-1:0];
               idx_in       = idx_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               eval_ctrl.eval = 1'b1;
               dist_a_we      = 1'b1;
               dist_b_we      = 1'b1;
               dist_waddr     = scan_node_ff[ADDR_W-1:0];
            end
            if (!(idx_ff < n_w) && !rd_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            idx_in   = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         walk_b_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_b_ff    <= walk_b_in;
      end
      cur_ff       <= cur_in;
      dist_ff      <= dist_in;
      fwd_ff       <= fwd_in;
      start_b_ff   <= start_b_in;
      scan_node_ff <= scan_node_in;
      if (rsp_load) begin
         rsp_item_ff <= '{found: best_found, meeting_node: best_node};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // successor table
   cmns_ram #(
      .WIDTH (SUCC_W),
      .DEPTH (NODE_DEPTH)
   ) u_succ_ram (
      .clock   (clock),
      .wr_en   (succ_we),
      .wr_addr (req_item.node_index[ADDR_W-1:0]),
      .wr_data (succ_wdata),
      .rd_addr (rd_addr),
      .rd_data (succ_rdata)
   );

   // distances from start a
   cmns_ram #(
      .WIDTH (DIST_W),
      .DEPTH (NODE_DEPTH)
   ) u_dist_a_ram (
      .clock   (clock),
      .wr_en   (dist_a_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (rd_addr),
      .rd_data (dist_a_rdata)
   );

   // distances from start b
   cmns_ram #(
      .WIDTH (DIST_W),
      .DEPTH (NODE_DEPTH)
   ) u_dist_b_ram (
      .clock   (clock),
      .wr_en   (dist_b_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (rd_addr),
      .rd_data (dist_b_rdata)
   );

   // shared compare unit
   cmns_best u_best (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (eval_ctrl),
      .node_limit   (n_w),
      .dist_a       (dist_a_rdata),
      .dist_b       (dist_b_rdata),
      .found        (best_found),
      .meeting_node (best_node)
   );

   // a walk never records more nodes than are in use
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (dist_ff <= n_w))
      else $error("walk distance beyond node count");

   // a walk write goes to a node in use
   assert property (@(posedge clock) disable iff (reset)
      walk_write |-> (COUNT_W'(cur_ff) < n_w))
      else $error("walk wrote a node out of range");

   // a finished query waits while the previous result is held
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FINISH))
      else $error("result loaded over a held result");

   // a query starts with the walk from start a
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_item.req_type == REQ_QUERY)
         |=> (state_ff == ST_WALK && !walk_b_ff && dist_ff == '0))
      else $error("query did not start walk a");

   // no meeting node without a hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.found) |-> (rsp_item_ff.meeting_node == '0))
      else $error("meeting node set without a hit");

endmodule
`default_nettype wire

// ===== sv/cmns_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cmns_ram
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module cmns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write, and read returning the old contents on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== sv/cmns_best.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cmns_best
// Compare unit of the scan: keeps the node whose larger distance is smallest.
// ---------------------------------------------------------------------------
module cmns_best
   import cmns_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire eval_ctrl_type       ctrl,
   input  wire logic [COUNT_W-1:0]  node_limit,
   input  wire logic [DIST_W-1:0]   dist_a,
   input  wire logic [DIST_W-1:0]   dist_b,
   output logic                     found,
   output logic [NODE_W-1:0]        meeting_node
);

   logic [COUNT_W-1:0] best_ff, best_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic               hit_ff, hit_in;
   logic [DIST_W-1:0]  far_dist;
   logic               both_reached;
   logic               better;

   // larger of the two distances, and whether it beats the best so far
   always_comb begin
      both_reached = (dist_a != UNREACHED) && (dist_b != UNREACHED);
      far_dist     = (dist_a > dist_b) ? dist_a : dist_b;
      better       = both_reached && (COUNT_W'(far_dist) < best_ff);
   end

   // next best, strict compare so the lowest index keeps a tie
   always_comb begin
      best_in = best_ff;
      node_in = node_ff;
      hit_in  = hit_ff;
      if (ctrl.init) begin
         best_in = node_limit;
         node_in = '0;
         hit_in  = 1'b0;
      end else if (ctrl.eval && better) begin
         best_in = COUNT_W'(far_dist);
         node_in = ctrl.node;
         hit_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      best_ff <= best_in;
      node_ff <= node_in;
   end

   assign found        = hit_ff;
   assign meeting_node = node_ff;

endmodule
`default_nettype wire

// ===== bench/closest_meeting_node_search_tb.sv =====
// ---------------------------------------------------------------------------
// closest_meeting_node_search_tb
// Self-checking bench for the closest meeting node search. A directed list
// covers the node count extremes, edges that leave the active range, starts
// beyond the active range, ties and an empty node count. Random phases then
// build small graphs and query them, with two phases on the full table.
// Every query result is checked against a listed expectation or a local
// search model. The sender and receiver idle at several rates, and once
// the receiver holds off long enough to back the block up.
// ---------------------------------------------------------------------------
module closest_meeting_node_search_tb;
   import cmns_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 500;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      req_item_type        item;
      logic [COUNT_W-1:0]  count;
      bit                  typed;
      rsp_item_type        want;
   } stim_row_type;

   // block ports
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid;
   logic               req_ready;
   req_item_type       req_item;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_item_type       rsp_item;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   // local copy of the graph and search state
   logic [SUCC_W-1:0]  succ_mem [TABLE_DEPTH];
   bit                 written_mem [TABLE_DEPTH];
   int                 written_nodes [$];
   logic [DIST_W-1:0]  reach_dist [2][TABLE_DEPTH];
   logic [COUNT_W-1:0] node_count_q;

   rsp_item_type       meeting_due [$];
   stim_row_type       directed_rows [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int sender_idle_pct;
   int stall_pct;
   bit hold_req = 1'b0;
   bit hold_ack;
   int hold_left;

   closest_meeting_node_search dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // walk one successor chain, flag any read of a never-written entry
   function automatic bit trace_chain(int side, int start, int n);
      int cur;
      int d;
      bit blind;
      cur = start;
      d = 0;
      blind = 1'b0;
      for (int s = 0; s < n; s++) begin
         if (cur >= n || reach_dist[side][cur] != UNREACHED) break;
         reach_dist[side][cur] = DIST_W'(d);
         d++;
         if (!written_mem[cur]) blind = 1'b1;
         if (!succ_mem[cur][NODE_W]) break;
         cur = succ_mem[cur][NODE_W-1:0];
      end
      return blind;
   endfunction

   // closest common node of two starts; returns 0 if the walks touch
   // entries that were never loaded
   function automatic bit search_meeting(logic [NODE_W-1:0] sa, logic [NODE_W-1:0] sb,
                                         output rsp_item_type res);
      int n;
      int best;
      int da;
      int db;
      int m;
      bit blind;
      n = node_count_q;
      if (n > MAX_NODES_DEFAULT) n = MAX_NODES_DEFAULT;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         reach_dist[0][i] = UNREACHED;
         reach_dist[1][i] = UNREACHED;
      end
      blind = trace_chain(0, sa, n);
      blind |= trace_chain(1, sb, n);
      best = n;
      res = '0;
      for (int i = 0; i < n; i++) begin
         da = reach_dist[0][i];
         db = reach_dist[1][i];
         if (da == UNREACHED || db == UNREACHED) continue;
         m = (da > db) ? da : db;
         if (m < best) begin
            best = m;
            res.found = 1'b1;
            res.meeting_node = NODE_W'(i);
         end
      end
      return !blind;
   endfunction

   // directed list builders
   function automatic stim_row_type fresh_row(row_kind_type kind);
      stim_row_type r;
      r.kind = kind;
      r.item = '0;
      r.count = '0;
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic void add_load(int idx, bit has, int tgt);
      stim_row_type r;
      r = fresh_row(ROW_ITEM);
      r.item.req_type = REQ_LOAD;
      r.item.node_index = NODE_W'(idx);
      r.item.has_edge = has;
      r.item.edge_target = NODE_W'(tgt);
      directed_rows.push_back(r);
   endfunction

   function automatic void add_query(int a, int b, bit typed, bit found, int node);
      stim_row_type r;
      r = fresh_row(ROW_ITEM);
      r.item.req_type = REQ_QUERY;
      r.item.start_a = NODE_W'(a);
      r.item.start_b = NODE_W'(b);
      r.typed = typed;
      r.want.found = found;
      r.want.meeting_node = NODE_W'(node);
      directed_rows.push_back(r);
   endfunction

   function automatic void add_count(int v);
      stim_row_type r;
      r = fresh_row(ROW_CSR);
      r.count = COUNT_W'(v);
      directed_rows.push_back(r);
   endfunction

   function automatic logic [NODE_W-1:0] pick_start(int n, bit own_graph);
      if (own_graph && n > 0 && $urandom_range(99) < 85)
         return NODE_W'($urandom_range(0, n - 1));
      if (written_nodes.size() != 0 && $urandom_range(99) < 70)
         return NODE_W'(written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
      return NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
   endfunction

   // present one item, record its effect once taken, then idle at random
   task automatic offer(req_item_type it, bit typed, rsp_item_type want);
      rsp_item_type predicted;
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (it.req_type == REQ_QUERY) begin
         void'(search_meeting(it.start_a, it.start_b, predicted));
         meeting_due.push_back(typed ? want : predicted);
      end else begin
         succ_mem[it.node_index] = it.has_edge ? {1'b1, it.edge_target} : '0;
         if (!written_mem[it.node_index]) begin
            written_mem[it.node_index] = 1'b1;
            written_nodes.push_back(it.node_index);
         end
      end
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // wait for every pending result, then let trailing loads finish
   task automatic settle(int extra);
      req_valid <= 1'b0;
      while (meeting_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_node_count(logic [COUNT_W-1:0] v);
      settle(16);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      node_count_q = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_load();
      req_item_type it;
      it.req_type = REQ_LOAD;
      it.node_index = NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.has_edge = ($urandom_range(99) < 80);
      if (written_nodes.size() != 0 && $urandom_range(99) < 70)
         it.edge_target = NODE_W'(written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
      else
         it.edge_target = NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.start_a = NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.start_b = NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
      offer(it, 1'b0, '0);
   endtask

   // query whose walks stay on loaded entries; falls back to a plain load
   task automatic send_random_query(int n, bit own_graph);
      req_item_type it;
      rsp_item_type scratch;
      bit legal;
      it.req_type = REQ_QUERY;
      it.node_index = NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.has_edge = 1'($urandom_range(0, 1));
      it.edge_target = NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.start_a = '0;
      it.start_b = '0;
      legal = 1'b0;
      for (int k = 0; k < 30 && !legal; k++) begin
         it.start_a = pick_start(n, own_graph);
         it.start_b = pick_start(n, own_graph);
         legal = search_meeting(it.start_a, it.start_b, scratch);
      end
      if (!legal) begin
         it.req_type = REQ_LOAD;
         it.has_edge = 1'b0;
      end
      offer(it, 1'b0, '0);
   endtask

   // small graph: load every active node, then query it
   task automatic run_small_phase(int gap, int stall, bit hold);
      int n;
      req_item_type it;
      n = $urandom_range(1, 12);
      write_node_count(COUNT_W'(n));
      sender_idle_pct = gap;
      stall_pct <= stall;
      for (int k = 0; k < n; k++) begin
         it.req_type = REQ_LOAD;
         it.node_index = NODE_W'(k);
         it.has_edge = ($urandom_range(99) < 85);
         if ($urandom_range(99) < 80)
            it.edge_target = NODE_W'($urandom_range(0, n - 1));
         else
            it.edge_target = NODE_W'($urandom_range(n, TABLE_DEPTH - 1));
         it.start_a = NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
         it.start_b = NODE_W'($urandom_range(0, TABLE_DEPTH - 1));
         offer(it, 1'b0, '0);
      end
      if (hold) hold_req <= ~hold_req;
      for (int k = 0; k < 16; k++) begin
         if ($urandom_range(99) < 12) send_random_load();
         else send_random_query(n, 1'b0 | 1'b1);
      end
   endtask

   // full table: scattered loads and long scans
   task automatic run_wide_phase(int gap, int stall);
      int pick;
      int n;
      logic [COUNT_W-1:0] v;
      pick = $urandom_range(0, 2);
      if (pick == 0) v = 11'd1024;
      else if (pick == 1) v = 11'd2047;
      else v = COUNT_W'($urandom_range(600, 1023));
      write_node_count(v);
      sender_idle_pct = gap;
      stall_pct <= stall;
      n = (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
      repeat (8) send_random_load();
      repeat (10) send_random_query(n, 1'b0);
   endtask

   // result side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_ack <= 1'b0;
         hold_left <= 0;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare each taken result with the oldest pending one
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (meeting_due.size() == 0) begin
            $display("%0t: unexpected result found=%0d node=%0d",
                     $time, rsp_item.found, rsp_item.meeting_node);
            mismatch_count++;
         end else begin
            want = meeting_due.pop_front();
            if (rsp_item.found !== want.found || rsp_item.meeting_node !== want.meeting_node)
            begin
               $display("%0t: mismatch expected found=%0d node=%0d actual found=%0d node=%0d",
                        $time, want.found, want.meeting_node,
                        rsp_item.found, rsp_item.meeting_node);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("closest_meeting_node_search_tb: errors");
         $finish;
      end
   end

   // stimulus
   initial begin
      int gap;
      int stall;
      req_valid = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      node_count_q = NODE_COUNT_RESET;
      sender_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         succ_mem[i] = '0;
         written_mem[i] = 1'b0;
      end

      // full table after reset: isolated nodes and a single edge
      add_load(0, 1'b0, 0);
      add_load(1023, 1'b0, 1023);
      add_query(0, 0, 1'b1, 1'b1, 0);
      add_query(1023, 1023, 1'b1, 1'b1, 1023);
      add_query(0, 1023, 1'b1, 1'b0, 0);
      add_load(1023, 1'b1, 0);
      add_query(1023, 0, 1'b1, 1'b1, 0);
      // two-node cycle: tie goes to the lower index, start out of range
      add_count(2);
      add_load(0, 1'b1, 1);
      add_load(1, 1'b1, 0);
      add_query(0, 1, 1'b1, 1'b1, 0);
      add_query(1023, 0, 1'b1, 1'b0, 0);
      // no nodes in use
      add_count(0);
      add_query(0, 0, 1'b1, 1'b0, 0);
      // single node whose edge leaves the range
      add_count(1);
      add_query(0, 0, 1'b1, 1'b1, 0);
      add_query(0, 1, 1'b1, 1'b0, 0);
      // chain ending in an edge beyond the range, then closed into a loop
      add_count(5);
      add_load(2, 1'b1, 3);
      add_load(3, 1'b1, 4);
      add_load(4, 1'b1, 1023);
      add_query(2, 0, 1'b0, 1'b0, 0);
      add_query(2, 4, 1'b0, 1'b0, 0);
      add_load(4, 1'b1, 2);
      add_query(3, 4, 1'b0, 1'b0, 0);
      // count above the table depth, alternating index bits
      add_count(2047);
      add_load(341, 1'b0, 682);
      add_load(682, 1'b1, 341);
      add_query(682, 341, 1'b1, 1'b1, 341);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_node_count(directed_rows[r].count);
         else
            offer(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end

      // random phases over the idling modes
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin
               gap = 0;
               stall = 0;
            end
            1: begin
               gap = 81;
               stall = 0;
            end
            2: begin
               gap = 0;
               stall = 81;
            end
            default: begin
               gap = 37;
               stall = 37;
            end
         endcase
         if (p == 2 || p == 5) run_wide_phase(gap, stall);
         else run_small_phase(gap, stall, 1'b0);
      end

      // receiver holds off while items keep coming
      run_small_phase(0, 0, 1'b1);

      settle(64);
      if (mismatch_count == 0)
         $display("closest_meeting_node_search_tb: clean");
      else
         $display("closest_meeting_node_search_tb: errors");
      $finish;
   end

endmodule
